// ===== hdl/salc_pkg.sv =====
// Shared types, constants and register codes for the set-associative LRU cache model.
// Used by every module of the block except salc_ram; it depends on nothing else.
`default_nettype none

package salc_pkg;

    // Default values for the top-level parameters.
    localparam int DEF_MAX_SET_BITS = 6;
    localparam int DEF_MAX_WAYS     = 8;
    localparam int DEF_ADDR_WIDTH   = 48;

    // Field widths that are fixed by the interface.
    localparam int CMD_W     = 2;
    localparam int OUTCOME_W = 2;
    localparam int TOTAL_W   = 32;
    localparam int OUT_PAYLOAD_W = OUTCOME_W + 3 * TOTAL_W;
    localparam int M_TDATA_W     = ((OUT_PAYLOAD_W + 7) / 8) * 8;

    // Configuration port.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_SET_BITS    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WAYS_IN_USE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_BITS  = 2'd2;

    localparam logic [2:0] RST_SET_BITS    = 3'd4;
    localparam logic [3:0] RST_WAYS_IN_USE = 4'd1;
    localparam logic [3:0] RST_BLOCK_BITS  = 4'd4;

    // Access commands; the unused code behaves as a load.
    localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_STORE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MODIFY = 2'd2;

    // Outcome of the first access of a word.
    localparam logic [OUTCOME_W-1:0] OUT_HIT   = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUT_FILL  = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUT_EVICT = 2'd2;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // Summary of one set lookup, passed from the way logic to the top level.
    typedef struct packed {
        logic hit;
        logic evict;
    } salc_look_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_LOOK = 2'b10
    } salc_state_t;

endpackage

`default_nettype wire

// ===== hdl/set_assoc_lru_cache_sim.sv =====
// Each accepted word is looked up in the LOOK state and its result queued, then offered
// on the m_ side. A new word is taken only in IDLE, once the read-modify-write of the
// last set row through the registered tag and age memories is done and the queue has room.
// Reset (synchronous, aresetn low): registers return to 4 set bits, one way and 4 block
// bits, the totals clear and every set row is marked empty at once; no clearing pass.
// Depends on salc_pkg, salc_ram and salc_way_logic.
`default_nettype none

module set_assoc_lru_cache_sim #(
    parameter int MAX_SET_BITS = salc_pkg::DEF_MAX_SET_BITS,
    parameter int MAX_WAYS     = salc_pkg::DEF_MAX_WAYS,
    parameter int ADDR_WIDTH   = salc_pkg::DEF_ADDR_WIDTH
) (
    input  wire logic aclk,
    input  wire logic aresetn,

    // Input words: command [1:0], address [ADDR_WIDTH+1:2], zero padding above.
    input  wire logic                                                  s_tvalid,
    output logic                                                       s_tready,
    input  wire logic [((ADDR_WIDTH + salc_pkg::CMD_W + 7) / 8) * 8 - 1:0] s_tdata,

    // Result words: outcome [1:0], total_hits [33:2], total_misses [65:34],
    // total_evictions [97:66], zero padding above.
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [salc_pkg::M_TDATA_W-1:0]     m_tdata,

    // Configuration writes, to be issued only while the block is idle.
    input  wire logic                              cfg_we,
    input  wire logic [salc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [salc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import salc_pkg::*;

    localparam int NUM_SETS = 1 << MAX_SET_BITS;
    localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int AGE_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int VA_W     = AGE_W + 1;
    localparam int WCNT_W   = $clog2(MAX_WAYS + 1);
    localparam int TAG_ROW_W = MAX_WAYS * ADDR_WIDTH;
    localparam int VA_ROW_W  = MAX_WAYS * VA_W;
    localparam int Q_DEPTH   = 2;

    // ------------------------------------------------------------------
    // Configuration registers and their effective values.
    // ------------------------------------------------------------------
    logic [2:0] set_bits_reg;
    logic [3:0] ways_reg;
    logic [3:0] block_bits_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            set_bits_reg   <= RST_SET_BITS;
            ways_reg       <= RST_WAYS_IN_USE;
            block_bits_reg <= RST_BLOCK_BITS;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_SET_BITS:    set_bits_reg   <= cfg_wdata[2:0];
                REG_WAYS_IN_USE: ways_reg       <= cfg_wdata[3:0];
                REG_BLOCK_BITS:  block_bits_reg <= cfg_wdata[3:0];
                default: begin
                end
            endcase
        end
    end

    // Set bits are clamped to what the memories hold; the way count to 1..MAX_WAYS.
    logic [3:0]        sb_eff;
    logic [4:0]        ways_wide;
    logic [WCNT_W-1:0] ways_eff;

    always_comb begin
        sb_eff = (4'(set_bits_reg) > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS)
                                                       : 4'(set_bits_reg);
        ways_wide = {1'b0, ways_reg};
        if (ways_wide == 5'd0) begin
            ways_eff = WCNT_W'(1);
        end else if (ways_wide > 5'(MAX_WAYS)) begin
            ways_eff = WCNT_W'(MAX_WAYS);
        end else begin
            ways_eff = WCNT_W'(ways_wide);
        end
    end

    // ------------------------------------------------------------------
    // Address split on acceptance: the set index goes straight to the
    // memories' read address, the tag and command are held for the lookup.
    // ------------------------------------------------------------------
    logic [CMD_W-1:0]      cmd_in;
    logic [ADDR_WIDTH-1:0] addr_in;
    logic [ADDR_WIDTH-1:0] addr_shifted;
    logic [SET_W-1:0]      set_mask;
    logic [SET_W-1:0]      set_in;
    logic [4:0]            tag_shift;
    logic [ADDR_WIDTH-1:0] tag_in;

    assign cmd_in  = s_tdata[CMD_W-1:0];
    assign addr_in = s_tdata[CMD_W +: ADDR_WIDTH];

    always_comb begin
        for (int i = 0; i < SET_W; i++) begin
            set_mask[i] = (4'(i) < sb_eff);
        end
        addr_shifted = addr_in >> block_bits_reg;
        set_in       = addr_shifted[SET_W-1:0] & set_mask;
        tag_shift    = {1'b0, block_bits_reg} + 5'(sb_eff);
        tag_in       = addr_in >> tag_shift;
    end

    // ------------------------------------------------------------------
    // Sequencer: IDLE takes a word and starts the row read, LOOK finishes
    // the lookup, writes the row back and queues the result.
    // ------------------------------------------------------------------
    salc_state_t state_reg;
    salc_state_t state_next;
    logic        accept;
    logic        look_now;
    logic [1:0]  q_cnt_reg;

    assign s_tready = (state_reg == ST_IDLE) && (q_cnt_reg != 2'(Q_DEPTH));
    assign accept   = s_tvalid && s_tready;
    assign look_now = (state_reg == ST_LOOK);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_LOOK;
            ST_LOOK: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    logic [SET_W-1:0]      set_reg;
    logic [ADDR_WIDTH-1:0] tag_reg;
    logic [CMD_W-1:0]      cmd_reg;

    always_ff @(posedge aclk) begin
        if (accept) begin
            set_reg <= set_in;
            tag_reg <= tag_in;
            cmd_reg <= cmd_in;
        end
    end

    // ------------------------------------------------------------------
    // Row memories. Each set is one row holding all ways. The valid and age
    // row has a per-row flag in flip-flops: a row never written reads as all
    // ways empty with age zero. The tag row needs no flag since a tag is only
    // compared when its way is valid.
    // ------------------------------------------------------------------
    logic [TAG_ROW_W-1:0] tag_rd;
    logic [TAG_ROW_W-1:0] tag_wr;
    logic [VA_ROW_W-1:0]  va_rd;
    logic [VA_ROW_W-1:0]  va_row;
    logic [VA_ROW_W-1:0]  va_wr;
    logic [NUM_SETS-1:0]  row_init_reg;

    salc_ram #(
        .WIDTH (TAG_ROW_W),
        .DEPTH (NUM_SETS)
    ) u_tag_ram (
        .aclk  (aclk),
        .we    (look_now),
        .waddr (set_reg),
        .wdata (tag_wr),
        .re    (accept),
        .raddr (set_in),
        .rdata (tag_rd)
    );

    salc_ram #(
        .WIDTH (VA_ROW_W),
        .DEPTH (NUM_SETS)
    ) u_age_ram (
        .aclk  (aclk),
        .we    (look_now),
        .waddr (set_reg),
        .wdata (va_wr),
        .re    (accept),
        .raddr (set_in),
        .rdata (va_rd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_init_reg <= '0;
        end else if (look_now) begin
            row_init_reg[set_reg] <= 1'b1;
        end
    end

    // The write-back lands before the next word can be accepted, so a read
    // of the same set always sees the updated row.
    assign va_row = row_init_reg[set_reg] ? va_rd : '0;

    salc_look_t look;

    salc_way_logic #(
        .MAX_WAYS   (MAX_WAYS),
        .ADDR_WIDTH (ADDR_WIDTH),
        .AGE_W      (AGE_W),
        .WCNT_W     (WCNT_W)
    ) u_way_logic (
        .tag_row     (tag_rd),
        .va_row      (va_row),
        .tag         (tag_reg),
        .ways        (ways_eff),
        .tag_row_new (tag_wr),
        .va_row_new  (va_wr),
        .look        (look)
    );

    // ------------------------------------------------------------------
    // Saturating totals. A modify adds a second hit for its store.
    // ------------------------------------------------------------------
    logic [TOTAL_W-1:0] hit_total_reg,   hit_total_next;
    logic [TOTAL_W-1:0] miss_total_reg,  miss_total_next;
    logic [TOTAL_W-1:0] evict_total_reg, evict_total_next;
    logic [1:0]         hit_inc;
    logic [TOTAL_W:0]   hit_sum;
    logic [OUTCOME_W-1:0] outcome;

    always_comb begin
        hit_inc = {1'b0, look.hit} + {1'b0, cmd_reg == CMD_MODIFY};
        hit_sum = {1'b0, hit_total_reg} + (TOTAL_W+1)'(hit_inc);
        hit_total_next = hit_sum[TOTAL_W] ? TOTAL_MAX : hit_sum[TOTAL_W-1:0];

        miss_total_next = miss_total_reg;
        if (!look.hit && miss_total_reg != TOTAL_MAX) begin
            miss_total_next = miss_total_reg + 1'b1;
        end
        evict_total_next = evict_total_reg;
        if (look.evict && evict_total_reg != TOTAL_MAX) begin
            evict_total_next = evict_total_reg + 1'b1;
        end

        priority if (look.hit) begin
            outcome = OUT_HIT;
        end else if (look.evict) begin
            outcome = OUT_EVICT;
        end else begin
            outcome = OUT_FILL;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_total_reg   <= '0;
            miss_total_reg  <= '0;
            evict_total_reg <= '0;
        end else if (look_now) begin
            hit_total_reg   <= hit_total_next;
            miss_total_reg  <= miss_total_next;
            evict_total_reg <= evict_total_next;
        end
    end

    // ------------------------------------------------------------------
    // Two-entry result queue, so a new word can be taken while a finished
    // result is still waiting on the m_ side.
    // ------------------------------------------------------------------
    logic [OUT_PAYLOAD_W-1:0] q_data_reg [Q_DEPTH];
    logic                     q_wr_ptr_reg;
    logic                     q_rd_ptr_reg;
    logic                     pop;
    logic [1:0]               q_cnt_next;

    assign m_tvalid = (q_cnt_reg != 2'd0);
    assign pop      = m_tvalid && m_tready;
    assign m_tdata  = {{(M_TDATA_W - OUT_PAYLOAD_W){1'b0}}, q_data_reg[q_rd_ptr_reg]};

    always_comb begin
        q_cnt_next = q_cnt_reg + 2'(look_now) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_cnt_reg    <= '0;
            q_wr_ptr_reg <= 1'b0;
            q_rd_ptr_reg <= 1'b0;
        end else begin
            q_cnt_reg <= q_cnt_next;
            if (look_now) begin
                q_wr_ptr_reg <= ~q_wr_ptr_reg;
            end
            if (pop) begin
                q_rd_ptr_reg <= ~q_rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (look_now) begin
            q_data_reg[q_wr_ptr_reg] <= {evict_total_next, miss_total_next,
                                         hit_total_next, outcome};
        end
    end

endmodule

`default_nettype wire

// ===== hdl/salc_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read port.
// Stand-alone; no package is needed.
`default_nettype none

module salc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                                      aclk,
    input  wire logic                                      we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic                                      re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/salc_way_logic.sv =====
// Way search, victim choice and age update for one set row of the cache.
// Depends on salc_pkg for the lookup summary type.
`default_nettype none

module salc_way_logic #(
    parameter int MAX_WAYS   = 8,
    parameter int ADDR_WIDTH = 48,
    parameter int AGE_W      = 3,
    parameter int WCNT_W     = 4
) (
    input  wire logic [MAX_WAYS*ADDR_WIDTH-1:0] tag_row,
    input  wire logic [MAX_WAYS*(AGE_W+1)-1:0]  va_row,
    input  wire logic [ADDR_WIDTH-1:0]          tag,
    input  wire logic [WCNT_W-1:0]              ways,
    output logic      [MAX_WAYS*ADDR_WIDTH-1:0] tag_row_new,
    output logic      [MAX_WAYS*(AGE_W+1)-1:0]  va_row_new,
    output salc_pkg::salc_look_t                look
);
    import salc_pkg::*;

    localparam int VA_W = AGE_W + 1;

    logic [MAX_WAYS-1:0] used;
    logic [MAX_WAYS-1:0] valid;
    logic [AGE_W-1:0]    age [MAX_WAYS];
    logic                hit;
    logic                free;
    logic [AGE_W-1:0]    hit_way;
    logic [AGE_W-1:0]    free_way;
    logic [AGE_W-1:0]    victim;
    logic [AGE_W-1:0]    way;
    logic [AGE_W:0]      ref_age;

    // Unpack the row; a way is in use when its number is below the way count.
    always_comb begin
        for (int w = 0; w < MAX_WAYS; w++) begin
            used[w]  = (WCNT_W'(w) < ways);
            valid[w] = va_row[w*VA_W + AGE_W];
            age[w]   = va_row[w*VA_W +: AGE_W];
        end
    end

    // Lowest matching way, lowest free way and the oldest way.
    always_comb begin
        hit      = 1'b0;
        hit_way  = '0;
        free     = 1'b0;
        free_way = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (used[w] && valid[w] && tag_row[w*ADDR_WIDTH +: ADDR_WIDTH] == tag) begin
                hit     = 1'b1;
                hit_way = AGE_W'(w);
            end
            if (used[w] && !valid[w]) begin
                free     = 1'b1;
                free_way = AGE_W'(w);
            end
        end
        victim = '0;
        for (int w = 1; w < MAX_WAYS; w++) begin
            if (used[w] && age[w] > age[victim]) begin
                victim = AGE_W'(w);
            end
        end
    end

    always_comb begin
        priority if (hit) begin
            way     = hit_way;
            ref_age = {1'b0, age[hit_way]};
        end else if (free) begin
            way     = free_way;
            ref_age = (AGE_W+1)'(MAX_WAYS);
        end else begin
            way     = victim;
            ref_age = {1'b0, age[victim]};
        end
        look.hit   = hit;
        look.evict = !hit && !free;
    end

    // The touched way becomes the newest; younger used ways age by one.
    always_comb begin
        tag_row_new = tag_row;
        va_row_new  = va_row;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (AGE_W'(w) == way) begin
                va_row_new[w*VA_W +: VA_W] = {1'b1, {AGE_W{1'b0}}};
                if (!hit) begin
                    tag_row_new[w*ADDR_WIDTH +: ADDR_WIDTH] = tag;
                end
            end else if (used[w] && valid[w] && {1'b0, age[w]} < ref_age &&
                         age[w] < AGE_W'(MAX_WAYS - 1)) begin
                va_row_new[w*VA_W +: AGE_W] = age[w] + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/salc_checker.sv =====
// Port-level checks for set_assoc_lru_cache_sim, attached by the bind at the end.
// Depends on salc_pkg for field widths.
`default_nettype none

module salc_checker #(
    parameter int ADDR_WIDTH = salc_pkg::DEF_ADDR_WIDTH
) (
    input wire logic                                                  aclk,
    input wire logic                                                  aresetn,
    input wire logic                                                  s_tvalid,
    input wire logic                                                  s_tready,
    input wire logic [((ADDR_WIDTH + salc_pkg::CMD_W + 7) / 8) * 8 - 1:0] s_tdata,
    input wire logic                                                  m_tvalid,
    input wire logic                                                  m_tready,
    input wire logic [salc_pkg::M_TDATA_W-1:0]                        m_tdata
);
    import salc_pkg::*;

    // One word is worked on at a time: no acceptance on the edge after one.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted on two consecutive edges");

    // A waiting input word is held unchanged until it is taken.
    a_input_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && !s_tready) |=> $stable(s_tdata))
        else $error("input word changed while waiting");

    // The outcome field never carries the unused code.
    a_outcome_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[1:0] == OUT_HIT || m_tdata[1:0] == OUT_FILL ||
                      m_tdata[1:0] == OUT_EVICT))
        else $error("result outcome has an unused code");

    // Every eviction is also a miss.
    a_evict_le_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[97:66] <= m_tdata[65:34]))
        else $error("eviction total exceeds miss total");

    // The hit total never falls from one result word to the next.
    a_hits_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready) ##1 m_tvalid |-> (m_tdata[33:2] >= $past(m_tdata[33:2])))
        else $error("hit total decreased");

endmodule

bind set_assoc_lru_cache_sim salc_checker #(
    .ADDR_WIDTH (ADDR_WIDTH)
) u_salc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== dv/salc_tag_checker.sv =====
`timescale 1ns / 100ps
// Checker for the set-associative LRU cache model: follows the input, result and
// configuration ports, replays every accepted access and compares the result words.
// Depends on salc_pkg.
module salc_tag_checker
    import salc_pkg::*;
#(
    parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
    parameter int MAX_WAYS     = DEF_MAX_WAYS,
    parameter int ADDR_WIDTH   = DEF_ADDR_WIDTH
) (
    input  wire logic                                              aclk,
    input  wire logic                                              aresetn,
    input  wire logic                                              s_tvalid,
    input  wire logic                                              s_tready,
    input  wire logic [((ADDR_WIDTH + CMD_W + 7) / 8) * 8 - 1:0]   s_tdata,
    input  wire logic                                              m_tvalid,
    input  wire logic                                              m_tready,
    input  wire logic [M_TDATA_W-1:0]                              m_tdata,
    input  wire logic                                              cfg_we,
    input  wire logic [CFG_INDEX_W-1:0]                            cfg_index,
    input  wire logic [CFG_DATA_W-1:0]                             cfg_wdata,
    output int                                                     pending_words,
    output int                                                     fail_count
);

    localparam int NUM_LINES = (1 << MAX_SET_BITS) * MAX_WAYS;
    localparam int AGE_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int AGE_TOP   = MAX_WAYS - 1;

    typedef struct packed {
        logic [OUTCOME_W-1:0] outcome;
        logic [TOTAL_W-1:0]   hits;
        logic [TOTAL_W-1:0]   misses;
        logic [TOTAL_W-1:0]   evictions;
    } access_result_t;

    // Shadow copy of the cache directory and of the registers.
    logic [ADDR_WIDTH-1:0] line_tag   [NUM_LINES];
    logic                  line_valid [NUM_LINES];
    logic [AGE_W-1:0]      line_age   [NUM_LINES];
    logic [TOTAL_W-1:0]    hit_tally, miss_tally, evict_count;
    logic [2:0]            cfg_set_bits;
    logic [3:0]            cfg_ways;
    logic [3:0]            cfg_block_bits;

    access_result_t access_results_q[$];
    int             failures;
    int             words_seen;

    function automatic logic [TOTAL_W-1:0] bump_total(input logic [TOTAL_W-1:0] v);
        return (v == TOTAL_MAX) ? v : v + 1'b1;
    endfunction

    // Makes one way the most recent; only ways younger than the reference age get older.
    function automatic void age_touch(input int base, input int ways, input int way,
                                      input int limit);
        int v;
        for (v = 0; v < ways; v++) begin
            if (v != way && line_valid[base + v] && int'(line_age[base + v]) < limit &&
                int'(line_age[base + v]) < AGE_TOP)
                line_age[base + v] = line_age[base + v] + 1'b1;
        end
        line_age[base + way] = '0;
    endfunction

    function automatic access_result_t replay_access(input logic [CMD_W-1:0] cmd,
                                                     input logic [ADDR_WIDTH-1:0] addr);
        int sb, ways, set_idx, base, w, hit_way, free_way, victim;
        logic [ADDR_WIDTH-1:0] shifted, tag;
        access_result_t r;
        sb = (int'(cfg_set_bits) > MAX_SET_BITS) ? MAX_SET_BITS : int'(cfg_set_bits);
        ways = (cfg_ways == 0) ? 1 : ((int'(cfg_ways) > MAX_WAYS) ? MAX_WAYS : int'(cfg_ways));
        shifted = addr >> cfg_block_bits;
        set_idx = int'(shifted[MAX_SET_BITS-1:0]) & ((1 << sb) - 1);
        tag = addr >> (int'(cfg_block_bits) + sb);
        base = set_idx * MAX_WAYS;
        hit_way = -1;
        free_way = -1;
        for (w = 0; w < ways; w++) begin
            if (hit_way < 0 && line_valid[base + w] && line_tag[base + w] == tag)
                hit_way = w;
            if (free_way < 0 && !line_valid[base + w])
                free_way = w;
        end
        if (hit_way >= 0) begin
            r.outcome = OUT_HIT;
            hit_tally = bump_total(hit_tally);
            age_touch(base, ways, hit_way, int'(line_age[base + hit_way]));
        end else begin
            miss_tally = bump_total(miss_tally);
            if (free_way >= 0) begin
                r.outcome = OUT_FILL;
                line_valid[base + free_way] = 1'b1;
                line_tag[base + free_way] = tag;
                age_touch(base, ways, free_way, MAX_WAYS);
            end else begin
                // The oldest used way goes; among equal ages the lowest-numbered one.
                r.outcome = OUT_EVICT;
                evict_count = bump_total(evict_count);
                victim = 0;
                for (w = 1; w < ways; w++)
                    if (line_age[base + w] > line_age[base + victim])
                        victim = w;
                line_tag[base + victim] = tag;
                age_touch(base, ways, victim, int'(line_age[base + victim]));
            end
        end
        // The store half of a modify always hits.
        if (cmd == CMD_MODIFY)
            hit_tally = bump_total(hit_tally);
        r.hits = hit_tally;
        r.misses = miss_tally;
        r.evictions = evict_count;
        return r;
    endfunction

    always @(posedge aclk) begin
        access_result_t want, got;
        if (!aresetn) begin
            for (int i = 0; i < NUM_LINES; i++) begin
                line_valid[i] = 1'b0;
                line_age[i] = '0;
            end
            hit_tally = '0;
            miss_tally = '0;
            evict_count = '0;
            cfg_set_bits = RST_SET_BITS;
            cfg_ways = RST_WAYS_IN_USE;
            cfg_block_bits = RST_BLOCK_BITS;
            access_results_q.delete();
            failures = 0;
            words_seen = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_SET_BITS:    cfg_set_bits = cfg_wdata[2:0];
                    REG_WAYS_IN_USE: cfg_ways = cfg_wdata[3:0];
                    REG_BLOCK_BITS:  cfg_block_bits = cfg_wdata[3:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                access_results_q.push_back(replay_access(s_tdata[CMD_W-1:0],
                                                         s_tdata[CMD_W +: ADDR_WIDTH]));
            if (m_tvalid && m_tready) begin
                got.outcome = m_tdata[OUTCOME_W-1:0];
                got.hits = m_tdata[OUTCOME_W +: TOTAL_W];
                got.misses = m_tdata[OUTCOME_W + TOTAL_W +: TOTAL_W];
                got.evictions = m_tdata[OUTCOME_W + 2 * TOTAL_W +: TOTAL_W];
                if (access_results_q.size() == 0) begin
                    if (failures < 10)
                        $display("[%0t] result word %0d arrived with nothing outstanding",
                                 $realtime, words_seen);
                    failures++;
                end else begin
                    want = access_results_q.pop_front();
                    if (got != want) begin
                        if (failures < 10)
                            $display({"[%0t] result word %0d mismatch (expected/actual): ",
                                      "outcome %0d/%0d hits %0d/%0d misses %0d/%0d ",
                                      "evictions %0d/%0d"},
                                     $realtime, words_seen, want.outcome, got.outcome,
                                     want.hits, got.hits, want.misses, got.misses,
                                     want.evictions, got.evictions);
                        failures++;
                    end
                end
                words_seen++;
            end
        end
        pending_words <= access_results_q.size();
        fail_count <= failures;
    end

endmodule

// ===== dv/set_assoc_lru_cache_sim_test.sv =====
`timescale 1ns / 100ps
// Top level of the cache model testbench: clock, reset, access stimulus, the result
// sink and the verdict.  Depends on salc_pkg, the block itself and salc_tag_checker.
module set_assoc_lru_cache_sim_test;
    import salc_pkg::*;

    localparam int ADDR_W    = DEF_ADDR_WIDTH;
    localparam int S_TDATA_W = ((ADDR_W + CMD_W + 7) / 8) * 8;

    // The unused command code, which the block treats as a load.
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

    // Idle chance in percent on both sides, outside the quiet phase.
    localparam int IDLE_PCT    = 34;
    // The result sink holds off once, for this many cycles, after this many input words.
    localparam int HOLD_AT     = 700;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_LIMIT = 5000;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_SET_BITS;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    int pending_words;
    int fail_count;
    int idle_pct = IDLE_PCT;
    int words_sent = 0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    set_assoc_lru_cache_sim dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    salc_tag_checker u_tag_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .pending_words (pending_words),
        .fail_count    (fail_count)
    );

    // Offers one access word, after a random number of idle cycles, and waits until it is
    // taken.  The valid line is left high on return so that back-to-back words need no
    // second assignment in the same step; an idle spell, settle or the drain lowers it.
    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tdata  <= S_TDATA_W'({addr, cmd});
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        words_sent++;
    endtask

    // Stops offering and waits until every result word has come back.  Since each word
    // gives exactly one result, the checker's pending count shows when all are back.
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_words != 0);
        repeat (4) @(posedge aclk);
    endtask

    // Writes all three registers on consecutive edges, keeping the write enable high
    // throughout.
    task automatic write_config(input int set_cfg, input int ways_cfg, input int block_cfg);
        cfg_we    <= 1'b1;
        cfg_index <= REG_SET_BITS;
        cfg_wdata <= CFG_DATA_W'(set_cfg);
        @(posedge aclk);
        cfg_index <= REG_WAYS_IN_USE;
        cfg_wdata <= CFG_DATA_W'(ways_cfg);
        @(posedge aclk);
        cfg_index <= REG_BLOCK_BITS;
        cfg_wdata <= CFG_DATA_W'(block_cfg);
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // One phase of random traffic under one setting.  Most words are built from a small
    // pool of tags and a handful of sets, so that sets fill, hit and evict; the rest are
    // fully random addresses that mostly miss.
    task automatic run_phase(input int set_cfg, input int ways_cfg, input int block_cfg,
                             input int count);
        logic [ADDR_W-1:0] tag_pool [10];
        logic [ADDR_W-1:0] addr, off_mask;
        int sb, ways, pool_n, i, k, set_sel;
        settle();
        write_config(set_cfg, ways_cfg, block_cfg);
        sb = (set_cfg > DEF_MAX_SET_BITS) ? DEF_MAX_SET_BITS : set_cfg;
        ways = (ways_cfg == 0) ? 1 : ((ways_cfg > DEF_MAX_WAYS) ? DEF_MAX_WAYS : ways_cfg);
        pool_n = ways + 2;
        for (i = 0; i < pool_n; i++)
            tag_pool[i] = ADDR_W'({$urandom, $urandom});
        off_mask = (ADDR_W'(1) << block_cfg) - ADDR_W'(1);
        for (i = 0; i < count; i++) begin
            if ($urandom_range(99) < 15) begin
                addr = ADDR_W'({$urandom, $urandom});
            end else begin
                k = $urandom_range(pool_n - 1);
                set_sel = $urandom_range(3) & ((1 << sb) - 1);
                addr = (tag_pool[k] << (block_cfg + sb)) |
                       (ADDR_W'(set_sel) << block_cfg) |
                       (ADDR_W'({$urandom, $urandom}) & off_mask);
            end
            send_word(CMD_W'($urandom_range(3)), addr);
        end
    endtask

    // Result sink: random back-pressure, plus one long hold-off while the sender keeps
    // offering, so that the block fills up and has to stall its input.
    initial begin : result_sink
        int hold_count;
        bit held;
        held = 1'b0;
        forever begin
            @(posedge aclk);
            if (!held && words_sent >= HOLD_AT) begin
                held = 1'b1;
                m_tready <= 1'b0;
                for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++)
                    @(posedge aclk);
            end
            m_tready <= ($urandom_range(99) >= idle_pct);
        end
    end

    initial begin : stimulus
        int drain_cycles;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed words under the reset setting: 4 set bits, one way, 4 block bits.
        // With a single way every miss in a used set evicts.
        send_word(CMD_LOAD,   48'h0000_0000_0000);  // fill of an empty set
        send_word(CMD_LOAD,   48'h0000_0000_0000);  // hit
        send_word(CMD_STORE,  48'h0000_0000_000F);  // hit, other byte of the same block
        send_word(CMD_MODIFY, 48'h0000_0000_0010);  // fill, plus the store hit
        send_word(CMD_MODIFY, 48'h0000_0000_0010);  // hit twice
        send_word(CMD_SPARE,  48'h0000_0000_0100);  // spare code as a load, evicts set 0
        send_word(CMD_LOAD,   48'h0000_0000_0000);  // evicts again
        send_word(CMD_LOAD,   48'hFFFF_FFFF_FFFF);  // highest address, last set
        send_word(CMD_MODIFY, 48'hFFFF_FFFF_FFFF);
        send_word(CMD_STORE,  48'h0000_0000_00F0);  // same set, tag zero
        send_word(CMD_LOAD,   48'h8000_0000_0000);  // top address bit alone
        send_word(CMD_STORE,  48'h5555_5555_5555);
        send_word(CMD_SPARE,  48'hAAAA_AAAA_AAAA);
        send_word(CMD_MODIFY, 48'h5555_5555_5555);

        // Settings change from phase to phase, with the out-of-range values
        // among them.  The directory is never flushed, so narrowing the ways after a
        // wide phase leaves tied ages behind for the victim choice.
        run_phase(RST_SET_BITS, RST_WAYS_IN_USE, RST_BLOCK_BITS, 100);
        run_phase(0, 8, 0, 120);
        run_phase(0, 3, 0, 100);
        run_phase(7, 15, 15, 120);
        run_phase(6, 0, 12, 100);
        idle_pct = 0;
        run_phase(2, 4, 13, 120);
        idle_pct = IDLE_PCT;
        run_phase(3, 8, 14, 120);
        run_phase($urandom_range(7), $urandom_range(15), $urandom_range(15), 100);

        // Drain with a bound, so that lost result words end the run instead of hanging it.
        s_tvalid <= 1'b0;
        drain_cycles = 0;
        do begin
            @(posedge aclk);
            drain_cycles++;
        end while (pending_words != 0 && drain_cycles < DRAIN_LIMIT);
        repeat (8) @(posedge aclk);
        if (pending_words != 0)
            $display("%0d result words never arrived", pending_words);
        if (fail_count == 0 && pending_words == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Far beyond the slowest correct run, long hold-off included.
    initial begin : watchdog
        #3_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
